>>> design/cowg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cowg_pkg
// Shared types and constants of the character-set odometer word generator.
// ----------------------------------------------------------------------------
package cowg_pkg;

   // widths fixed by the word formats
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 4;
   localparam int WLEN_W  = 5;
   localparam int WORD_CAP = 16;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd8;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_STEP    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [POS_W-1:0]      position;
      logic [CHAR_W-1:0]     character;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]     out_char;
      logic [POS_W-1:0]      out_position;
      logic                  last_of_word;
      logic                  final_word;
      logic                  no_word;
   } rsp_type;

   // odometer control from the sequencer
   typedef struct packed {
      logic                  clear;
      logic                  advance;
      logic                  last;
      logic [POS_W-1:0]      nx;
   } odo_ctl_type;

endpackage

>>> design/cowg_odometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cowg_odometer
// Mixed-radix digit registers with the exhausted flag and one read port.
// ----------------------------------------------------------------------------
module cowg_odometer import cowg_pkg::*; #(
   parameter int MAX_POSITIONS = 16,
   parameter int SET_DEPTH     = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  odo_ctl_type          odo_ctl,
   input  logic [POS_W-1:0]     rd_pos,
   output logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] rd_digit,
   output logic                 exhausted
);

   localparam int DW  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CAP = (MAX_POSITIONS < WORD_CAP) ? MAX_POSITIONS : WORD_CAP;
   localparam int OW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int ND  = 2 ** OW;

   logic [DW-1:0] digits_ff [ND];
   logic [DW-1:0] digits_in [ND];
   logic          exhausted_ff;
   logic          exhausted_in;

   function automatic logic [OW-1:0] to_oidx(input logic [POS_W-1:0] p);
      logic [OW+POS_W-1:0] w;
      w = {{OW{1'b0}}, p};
      return w[OW-1:0];
   endfunction

   assign rd_digit  = digits_ff[to_oidx(rd_pos)];
   assign exhausted = exhausted_ff;

   always_comb begin
      digits_in    = digits_ff;
      exhausted_in = exhausted_ff;
      if (odo_ctl.clear) begin
         for (int i = 0; i < ND; i++) digits_in[i] = '0;
         exhausted_in = 1'b0;
      end else if (odo_ctl.advance) begin
         if (odo_ctl.last) begin
            exhausted_in = 1'b1;
         end else begin
            // bump the advancing digit, zero everything to its right
            for (int i = 0; i < ND; i++) begin
               if (7'(i) > {3'b000, odo_ctl.nx}) digits_in[i] = '0;
            end
            digits_in[to_oidx(odo_ctl.nx)] = digits_ff[to_oidx(odo_ctl.nx)] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ND; i++) digits_ff[i] <= '0;
         exhausted_ff <= 1'b0;
      end else begin
         digits_ff    <= digits_in;
         exhausted_ff <= exhausted_in;
      end
   end

endmodule

>>> design/charset_odometer_word_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_odometer_word_generator
// Per-position character sets in one synchronous memory, odometer stepping.
// ----------------------------------------------------------------------------
// edit: accept, then a walk of the set at one entry a cycle through the registered
//   read; a remove closes its gap inside that same walk; restart is done at
//   accept
// step: accept, a right-to-left scan of the digits, then one character word per position
//   at one a cycle unless stalled, or one flagged word if a set is empty or the odometer is exhausted
// reset: synchronous; sizes, odometer, exhausted clear, length 8, memory kept
// ----------------------------------------------------------------------------
module charset_odometer_word_generator import cowg_pkg::*; #(
   parameter int MAX_POSITIONS = 16,
   parameter int SET_DEPTH     = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // edit and step words
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // character words
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // word length register
   input  logic                 csr_we,
   input  logic [WLEN_W-1:0]    csr_wdata
);

   // sizes that follow from the parameters
   localparam int DW  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;       // entry index
   localparam int CW  = $clog2(SET_DEPTH + 1);                         // set size
   localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int AW  = PW + DW;
   localparam int MEM_DEPTH = (2 ** PW) << DW;
   localparam int CAP = (MAX_POSITIONS < WORD_CAP) ? MAX_POSITIONS : WORD_CAP;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,   // walk the set looking for the character
      S_SHIFT,    // close the gap left by a removed character
      S_SCAN,     // right to left over the digits: empty sets and carry point
      S_NOWORD,   // single flagged word
      S_EMIT      // one character word per cycle unless stalled
   } state_type;

   // sequencer state
   state_type        state_ff, state_in;
   cmd_type          op_ff, op_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [DW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [POS_W-1:0] step_p_ff, step_p_in;
   logic             empty_ff, empty_in;
   logic             found_ff, found_in;
   logic             last_ff, last_in;
   logic [POS_W-1:0] nx_ff, nx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;

   // set sizes
   logic [CW-1:0]    counts_ff [2 ** PW];
   logic             cnt_inc, cnt_dec;

   // character memory
   logic [CHAR_W-1:0] set_mem [MEM_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;

   // odometer
   odo_ctl_type       odo_ctl;
   logic [POS_W-1:0]  odo_rd_pos;
   logic [DW-1:0]     odo_digit;
   logic              exhausted;

   logic              req_take, rsp_free;
   logic [WLEN_W-1:0] eff_len;
   logic [POS_W-1:0]  last_pos;
   logic [CW-1:0]     cur_cnt;
   logic [CW-1:0]     step_cnt;
   logic              issue, hit, adv, empty_n, found_n, pos_ok;

   function automatic logic [PW-1:0] to_pidx(input logic [POS_W-1:0] p);
      logic [PW+POS_W-1:0] w;
      w = {{PW{1'b0}}, p};
      return w[PW-1:0];
   endfunction

   cowg_odometer #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .SET_DEPTH     (SET_DEPTH)
   ) u_odometer (
      .clock     (clock),
      .reset     (reset),
      .odo_ctl   (odo_ctl),
      .rd_pos    (odo_rd_pos),
      .rd_digit  (odo_digit),
      .exhausted (exhausted)
   );

   // only idle takes a new word; a pending result does not block it
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // effective word length: zero acts as one, clipped to the position cap
   always_comb begin
      eff_len = wlen_ff;
      if (wlen_ff == '0) eff_len = WLEN_W'(1);
      if (wlen_ff > WLEN_W'(CAP)) eff_len = WLEN_W'(CAP);
   end
   assign last_pos = POS_W'(eff_len - WLEN_W'(1));

   assign cur_cnt  = counts_ff[pos_ff];
   assign step_cnt = counts_ff[to_pidx(step_p_ff)];
   assign issue    = (rd_idx_ff < cur_cnt);
   assign hit      = cmp_vld_ff && (rd_data_ff == char_ff);
   assign pos_ok   = ({3'b000, req_data.position} < 7'(MAX_POSITIONS));

   // scan step: a digit advances when digit + 1 stays below its set size
   assign adv      = ({1'b0, {(CW - DW){1'b0}}, odo_digit} + 1'b1) < {1'b0, step_cnt};
   assign empty_n  = empty_ff || (step_cnt == '0);
   assign found_n  = found_ff || adv;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      char_in      = char_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      step_p_in    = step_p_ff;
      empty_in     = empty_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      nx_in        = nx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wlen_in      = csr_we ? csr_wdata : wlen_ff;
      cnt_inc      = 1'b0;
      cnt_dec      = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = {pos_ff, rd_idx_ff[DW-1:0]};
      mem_we       = 1'b0;
      mem_waddr    = {pos_ff, DW'(cmp_idx_ff - 1'b1)};
      mem_wdata    = rd_data_ff;
      odo_ctl      = '0;
      odo_ctl.clear = csr_we;
      odo_ctl.nx   = nx_ff;
      odo_ctl.last = last_ff;
      odo_rd_pos   = step_p_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in   = req_data.cmd;
               pos_in  = to_pidx(req_data.position);
               char_in = req_data.character;
               unique case (req_data.cmd)
                  CMD_ADD, CMD_REMOVE: begin
                     odo_ctl.clear = 1'b1;
                     rd_idx_in     = '0;
                     // edits to positions without a set only restart
                     if (pos_ok) state_in = S_SEARCH;
                  end
                  CMD_RESTART: begin
                     odo_ctl.clear = 1'b1;
                  end
                  CMD_STEP: begin
                     step_p_in = last_pos;
                     empty_in  = 1'b0;
                     found_in  = 1'b0;
                     nx_in     = '0;
                     state_in  = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         S_SEARCH: begin
            // one read issued per cycle, compared in the following cycle
            if (issue) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            cmp_vld_in = issue;
            cmp_idx_in = rd_idx_ff[DW-1:0];
            if (hit) begin
               // a found add changes nothing, a found remove starts the shift
               state_in = (op_ff == CMD_REMOVE) ? S_SHIFT : S_IDLE;
            end else if (!issue && !cmp_vld_ff) begin
               if (op_ff == CMD_ADD && cur_cnt < CW'(SET_DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_waddr = {pos_ff, cur_cnt[DW-1:0]};
                  mem_wdata = char_ff;
                  cnt_inc   = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         S_SHIFT: begin
            // entry i+1 read last cycle is written to entry i
            if (issue) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            cmp_vld_in = issue;
            cmp_idx_in = rd_idx_ff[DW-1:0];
            if (cmp_vld_ff) mem_we = 1'b1;
            if (!issue && !cmp_vld_ff) begin
               cnt_dec  = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_SCAN: begin
            if (!found_ff && adv) nx_in = step_p_ff;
            empty_in = empty_n;
            found_in = found_n;
            if (step_p_ff == '0) begin
               last_in = !found_n;
               if (empty_n || exhausted) begin
                  state_in = S_NOWORD;
               end else begin
                  // digit of position 0 is on the read port this cycle
                  mem_re    = 1'b1;
                  mem_raddr = {to_pidx(step_p_ff), odo_digit};
                  state_in  = S_EMIT;
               end
            end else begin
               step_p_in = step_p_ff - 1'b1;
            end
         end

         S_NOWORD: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = '0;
               rsp_data_in.last_of_word  = 1'b1;
               rsp_data_in.no_word       = 1'b1;
               state_in                  = S_IDLE;
            end
         end

         S_EMIT: begin
            odo_rd_pos = step_p_ff + 1'b1;
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_char      = rd_data_ff;
               rsp_data_in.out_position  = step_p_ff;
               rsp_data_in.last_of_word  = (step_p_ff == last_pos);
               rsp_data_in.final_word    = last_ff;
               rsp_data_in.no_word       = 1'b0;
               if (step_p_ff == last_pos) begin
                  odo_ctl.advance = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  // fetch the next position while this word goes out
                  mem_re    = 1'b1;
                  mem_raddr = {to_pidx(odo_rd_pos), odo_digit};
                  step_p_in = step_p_ff + 1'b1;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         wlen_ff      <= WLEN_RESET;
         empty_ff     <= 1'b0;
         found_ff     <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         wlen_ff      <= wlen_in;
         empty_ff     <= empty_in;
         found_ff     <= found_in;
         last_ff      <= last_in;
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      char_ff     <= char_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      step_p_ff   <= step_p_in;
      nx_ff       <= nx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // set sizes, one entry touched per edit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2 ** PW; i++) counts_ff[i] <= '0;
      end else if (cnt_inc) begin
         counts_ff[pos_ff] <= counts_ff[pos_ff] + 1'b1;
      end else if (cnt_dec) begin
         counts_ff[pos_ff] <= counts_ff[pos_ff] - 1'b1;
      end
   end

   // character store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) set_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= set_mem[mem_raddr];
   end

   // a flagged word carries no character and closes its word
   a_noword_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.no_word) |->
         (rsp_data_ff.last_of_word && !rsp_data_ff.final_word &&
          rsp_data_ff.out_char == '0))
      else $error("flagged word with character fields set");

   // the set walk never reads past the set size
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_SHIFT) |->
         (rd_idx_ff <= cur_cnt && cur_cnt <= CW'(SET_DEPTH)))
      else $error("set walk beyond set size");

   // emission stays inside the word
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ({1'b0, step_p_ff} < eff_len))
      else $error("emit position beyond word length");

   // a finished word leaves the sequencer idle
   a_word_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_free && step_p_ff == last_pos) |=>
         (state_ff == S_IDLE && rsp_valid_ff && rsp_data_ff.last_of_word))
      else $error("word end not followed by idle");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character-set odometer word generator. A
// shadow copy of the character sets and the odometer predicts every character
// word; directed edits and steps come first, then random edit/step episodes
// under three idle mixes and a pass with one set filled to capacity.
// ----------------------------------------------------------------------------
module tb import cowg_pkg::*;;

   localparam int MAX_POSITIONS = 16;
   localparam int SET_DEPTH     = 256;
   // longest edit: one walk through the whole set, search and shift together
   localparam int SETTLE_CYCLES = 600;

   // shadow of the sets and the odometer, plus the queue of predicted words
   class odometer_shadow;
      logic [CHAR_W-1:0] set_chars [MAX_POSITIONS][SET_DEPTH];
      int unsigned       set_size  [MAX_POSITIONS];
      int unsigned       digit     [MAX_POSITIONS];
      bit                exhausted;
      logic [WLEN_W-1:0] length_reg;
      rsp_type           expected_words [$];
      int unsigned       mismatches;
      int unsigned       words_checked;

      function new();
         for (int p = 0; p < MAX_POSITIONS; p++) begin
            set_size[p] = 0;
            for (int i = 0; i < SET_DEPTH; i++) set_chars[p][i] = '0;
         end
         clear_odometer();
         length_reg    = WLEN_RESET;
         mismatches    = 0;
         words_checked = 0;
      endfunction

      function void clear_odometer();
         for (int p = 0; p < MAX_POSITIONS; p++) digit[p] = 0;
         exhausted = 1'b0;
      endfunction

      // zero acts as one, anything past the position count is clipped
      function int unsigned active_length();
         int unsigned n;
         n = 32'(length_reg);
         if (n < 1) n = 1;
         if (n > MAX_POSITIONS) n = MAX_POSITIONS;
         if (n > WORD_CAP) n = WORD_CAP;
         return n;
      endfunction

      function int find_char(int unsigned p, logic [CHAR_W-1:0] c);
         for (int i = 0; i < set_size[p]; i++)
            if (set_chars[p][i] == c) return i;
         return -1;
      endfunction

      // number of words left from a cleared odometer, clipped at 1000
      function int unsigned combinations(int unsigned n);
         int unsigned prod;
         prod = 1;
         for (int p = 0; p < n; p++) begin
            prod = prod * set_size[p];
            if (prod > 1000) prod = 1000;
         end
         return prod;
      endfunction

      function void take_length(logic [WLEN_W-1:0] v);
         length_reg = v;
         clear_odometer();
      endfunction

      function void take_request(req_type w);
         int          at;
         int unsigned p;
         p = 32'(w.position);
         case (w.cmd)
            CMD_ADD: begin
               at = find_char(p, w.character);
               if (at < 0 && set_size[p] < SET_DEPTH) begin
                  set_chars[p][set_size[p]] = w.character;
                  set_size[p]++;
               end
               clear_odometer();
            end
            CMD_REMOVE: begin
               at = find_char(p, w.character);
               if (at >= 0) begin
                  for (int i = at; i + 1 < set_size[p]; i++)
                     set_chars[p][i] = set_chars[p][i + 1];
                  set_size[p]--;
               end
               clear_odometer();
            end
            CMD_RESTART: clear_odometer();
            default: emit_word();
         endcase
      endfunction

      function void emit_word();
         int unsigned n;
         int          nx;
         bit          empty;
         bit          last;
         rsp_type     w;
         n     = active_length();
         empty = 1'b0;
         for (int p = 0; p < n; p++)
            if (set_size[p] == 0) empty = 1'b1;
         if (empty || exhausted) begin
            w.out_char     = '0;
            w.out_position = '0;
            w.last_of_word = 1'b1;
            w.final_word   = 1'b0;
            w.no_word      = 1'b1;
            expected_words.insert(expected_words.size(), w);
            return;
         end
         // rightmost position that still has a character to move on to
         nx = int'(n) - 1;
         while (nx >= 0 && digit[nx] + 1 >= set_size[nx]) nx--;
         last = (nx < 0);
         for (int p = 0; p < n; p++) begin
            w.out_char     = set_chars[p][digit[p]];
            w.out_position = POS_W'(p);
            w.last_of_word = (p + 1 == n);
            w.final_word   = last;
            w.no_word      = 1'b0;
            expected_words.insert(expected_words.size(), w);
         end
         if (last) begin
            exhausted = 1'b1;
         end else begin
            digit[nx] = (digit[nx] + 1) & 32'hFF;
            for (int p = nx + 1; p < n; p++) digit[p] = 0;
         end
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s is %0h, expected %0h in character word %0d",
                             name, got, want, words_checked));
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            report($sformatf("character word %h arrived with nothing expected", got));
            return;
         end
         want = expected_words.pop_front();
         check_field("out_char", got.out_char, want.out_char);
         check_field("out_position", 8'(got.out_position), 8'(want.out_position));
         check_field("last_of_word", 8'(got.last_of_word), 8'(want.last_of_word));
         check_field("final_word", 8'(got.final_word), 8'(want.final_word));
         check_field("no_word", 8'(got.no_word), 8'(want.no_word));
      endtask
   endclass

   // all inputs known from time zero
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [WLEN_W-1:0] csr_wdata = '0;

   odometer_shadow shadow;
   int unsigned    send_idle = 17;  // percent of cycles the sender holds off
   int unsigned    recv_idle = 83;  // percent of cycles the receiver stalls
   int unsigned    items_sent;
   int unsigned    random_words;
   int unsigned    length_writes;

   charset_odometer_word_generator #(
      .MAX_POSITIONS(MAX_POSITIONS),
      .SET_DEPTH    (SET_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // safety net against a hung handshake
   initial begin
      #10_000_000;
      $display("timed out with %0d character words outstanding", shadow.pending());
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stall, check every accepted character word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) shadow.check_word(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // one edit or step word; valid stays up after acceptance so a back-to-back
   // word needs only one assignment in the next call
   task automatic send_word(cmd_type c, logic [POS_W-1:0] p, logic [CHAR_W-1:0] ch);
      req_type w;
      w.cmd       = c;
      w.position  = p;
      w.character = ch;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_request(w);
      items_sent++;
   endtask

   // step words carry random don't-care position and character bits
   task automatic step_word();
      send_word(CMD_STEP, POS_W'($urandom), CHAR_W'($urandom));
   endtask

   // wait out all expected words and any edit still searching its set
   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [WLEN_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow.take_length(v);
      length_writes++;
   endtask

   // new length only while idle; extremes beyond the legal range included
   task automatic change_length();
      logic [WLEN_W-1:0] v;
      case ($urandom_range(7))
         0:       v = 5'd0;
         1:       v = 5'd1;
         2:       v = 5'd16;
         3:       v = 5'd31;
         4:       v = 5'd17;
         default: v = WLEN_W'($urandom_range(2, 15));
      endcase
      drain();
      write_length(v);
   endtask

   task automatic directed_words();
      step_word();                              // all sets empty at reset
      send_word(CMD_ADD, 4'd0, 8'h00);
      send_word(CMD_ADD, 4'd0, 8'hFF);
      send_word(CMD_ADD, 4'd0, 8'h00);          // duplicate add
      send_word(CMD_ADD, 4'd1, 8'h41);
      for (int p = 2; p < 8; p++)
         send_word(CMD_ADD, POS_W'(p), CHAR_W'(8'h30 + p));
      send_word(CMD_ADD, 4'd15, 8'h7E);         // beyond the reset length of 8
      step_word();
      step_word();                              // final combination
      step_word();                              // exhausted
      send_word(CMD_RESTART, 4'd9, 8'hAA);
      step_word();
      send_word(CMD_REMOVE, 4'd0, 8'h55);       // absent byte still clears odometer
      send_word(CMD_ADD, 4'd1, 8'h42);
      send_word(CMD_ADD, 4'd1, 8'h43);
      send_word(CMD_REMOVE, 4'd1, 8'h42);       // middle entry, later ones shift
      step_word();
      step_word();
      send_word(CMD_REMOVE, 4'd3, 8'h33);       // leaves position 3 empty
      step_word();
   endtask

   // mostly well-formed: fill the active sets small, then walk the whole
   // enumeration past its end; a little noise and the odd restart mixed in
   task automatic run_episode();
      int unsigned n, p, combos, steps, restart_at, start;
      start = items_sent;
      n     = shadow.active_length();
      for (p = 0; p < n; p++)
         if (shadow.set_size[p] == 0 && $urandom_range(15) != 0)
            send_word(CMD_ADD, POS_W'(p), CHAR_W'($urandom));
      repeat ($urandom_range(3)) begin
         p = $urandom_range(n - 1);
         if (shadow.set_size[p] > 0 &&
             shadow.combinations(n) / shadow.set_size[p] * (shadow.set_size[p] + 1) <= 16)
            send_word(CMD_ADD, POS_W'(p), CHAR_W'($urandom));
      end
      case ($urandom_range(5))
         0: begin
            p = $urandom_range(MAX_POSITIONS - 1);
            if (shadow.set_size[p] > 0)
               send_word(CMD_REMOVE, POS_W'(p),
                         shadow.set_chars[p][$urandom_range(shadow.set_size[p] - 1)]);
         end
         1: send_word(CMD_REMOVE, POS_W'($urandom), CHAR_W'($urandom));
         2: send_word(CMD_ADD, POS_W'($urandom), CHAR_W'($urandom));
         3: send_word(CMD_RESTART, POS_W'($urandom), CHAR_W'($urandom));
         default: ;
      endcase
      combos     = shadow.combinations(n);
      steps      = (combos >= 1 && combos <= 20) ? combos + 1 : $urandom_range(1, 3);
      restart_at = ($urandom_range(4) == 0) ? $urandom_range(steps - 1) : steps;
      for (int i = 0; i < steps; i++) begin
         if (i == restart_at) send_word(CMD_RESTART, POS_W'($urandom), CHAR_W'($urandom));
         step_word();
      end
      random_words += items_sent - start;
   endtask

   // one set filled with every byte, then an add that cannot fit
   task automatic fill_full_set();
      int unsigned first, stride;
      drain();
      write_length(5'd16);
      first  = $urandom_range(255);
      stride = 2 * $urandom_range(127) + 1;  // odd stride walks all 256 bytes
      for (int i = 0; i < SET_DEPTH; i++)
         send_word(CMD_ADD, 4'd15, CHAR_W'(first + i * stride));
      send_word(CMD_ADD, 4'd15, CHAR_W'($urandom));
      for (int p = 0; p < 15; p++)
         if (shadow.set_size[p] == 0) send_word(CMD_ADD, POS_W'(p), CHAR_W'($urandom));
      repeat (6) step_word();
      send_word(CMD_REMOVE, 4'd15, shadow.set_chars[15][128]);
      repeat (3) step_word();
      send_word(CMD_REMOVE, 4'd15, shadow.set_chars[15][0]);
      repeat (2) step_word();
      send_word(CMD_ADD, 4'd15, CHAR_W'($urandom));
      step_word();
   endtask

   initial begin
      shadow        = new();
      items_sent    = 0;
      random_words  = 0;
      length_writes = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      directed_words();
      while (random_words < 15) begin
         if ($urandom_range(1) == 0) change_length();
         run_episode();
      end

      // sender mostly idle, receiver mostly ready
      drain();
      send_idle = 83;
      recv_idle = 17;
      while (random_words < 30) begin
         if ($urandom_range(1) == 0) change_length();
         run_episode();
      end
      fill_full_set();

      // no idling on either side
      drain();
      send_idle = 0;
      recv_idle = 0;
      while (random_words < 45) begin
         if ($urandom_range(1) == 0) change_length();
         run_episode();
      end
      drain();

      $display("covered %0d edit/step words (%0d random) over %0d length settings",
               items_sent, random_words, length_writes);
      $display("checked %0d character words, %0d mismatches",
               shadow.words_checked, shadow.mismatches);
      if (shadow.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
